### rtl/etl_pkg.sv
// etl_pkg: shared types and constants for the epee touch lockout core.
// No dependencies; used by etl_csr, etl_side and epee_touch_lockout_core.
`timescale 1ns / 1ps
`default_nettype none

package etl_pkg;

   // Register reset values, microseconds
   localparam logic [31:0] LOCKOUT_RESET_US = 32'd45000;
   localparam logic [31:0] DEPRESS_RESET_US = 32'd2000;

   localparam int CSR_IDX_BITS = 1;

   typedef enum logic [CSR_IDX_BITS-1:0] {
      CSR_LOCKOUT_TIME = 1'b0,
      CSR_DEPRESS_TIME = 1'b1
   } csr_index_type;

   // Per-fencer status toward the lockout decision
   typedef struct packed {
      logic aged;          // touch is at least lockout time old
      logic touched;       // touch flag before this poll
      logic touched_next;  // touch flag after this poll
   } side_status_type;

endpackage

`default_nettype wire

### rtl/etl_csr.sv
// etl_csr: lockout and depress time registers with their write port.
// Depends on etl_pkg for reset values and register indexes.
`timescale 1ns / 1ps
`default_nettype none

module etl_csr (
   input  wire logic                              clock,
   input  wire logic                              reset,
   input  wire logic                              csr_valid,
   output      logic                              csr_ready,
   input  wire logic [etl_pkg::CSR_IDX_BITS-1:0]  csr_index,
   input  wire logic [31:0]                       csr_wdata,
   output      logic [31:0]                       lockout_time,
   output      logic [31:0]                       depress_time
);

   logic [31:0] lockout_ff, lockout_in;
   logic [31:0] depress_ff, depress_in;

   assign csr_ready = 1'b1;

   always_comb begin
      lockout_in = lockout_ff;
      depress_in = depress_ff;
      if (csr_valid) begin
         unique case (etl_pkg::csr_index_type'(csr_index))
            etl_pkg::CSR_LOCKOUT_TIME: lockout_in = csr_wdata;
            etl_pkg::CSR_DEPRESS_TIME: depress_in = csr_wdata;
            default: ;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         lockout_ff <= etl_pkg::LOCKOUT_RESET_US;
         depress_ff <= etl_pkg::DEPRESS_RESET_US;
      end else begin
         lockout_ff <= lockout_in;
         depress_ff <= depress_in;
      end
   end

   assign lockout_time = lockout_ff;
   assign depress_time = depress_ff;

endmodule

`default_nettype wire

### rtl/etl_side.sv
// etl_side: one fencer's press timer and touch flag.
// Depends on etl_pkg for side_status_type.
`timescale 1ns / 1ps
`default_nettype none

module etl_side #(
   parameter int TIME_BITS = 32
) (
   input  wire logic                   clock,
   input  wire logic                   reset,
   input  wire logic [TIME_BITS-1:0]   now,
   input  wire logic                   contact,
   input  wire logic                   update,
   input  wire logic [31:0]            lockout_time,
   input  wire logic [31:0]            depress_time,
   output      etl_pkg::side_status_type status
);

   localparam int CMP_BITS = (TIME_BITS > 32) ? TIME_BITS : 32;

   logic                 touched_ff, touched_in;
   logic                 pressing_ff, pressing_in;
   logic [TIME_BITS-1:0] start_ff, start_in;
   logic [TIME_BITS-1:0] elapsed;
   logic [CMP_BITS-1:0]  elapsed_x;
   logic                 aged;
   logic                 held;

   // modular age of the press start, compared at the wider of the two widths
   assign elapsed   = now - start_ff;
   assign elapsed_x = CMP_BITS'(elapsed);
   assign aged      = touched_ff && (elapsed_x >= CMP_BITS'(lockout_time));
   assign held      = elapsed_x >= CMP_BITS'(depress_time);

   always_comb begin
      touched_in  = touched_ff;
      pressing_in = pressing_ff;
      start_in    = start_ff;
      if (update && !touched_ff) begin
         if (contact) begin
            if (pressing_ff) begin
               if (held) begin
                  touched_in = 1'b1;
               end
            end else begin
               start_in    = now;
               pressing_in = 1'b1;
            end
         end else if (pressing_ff) begin
            start_in    = '0;
            pressing_in = 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         touched_ff  <= 1'b0;
         pressing_ff <= 1'b0;
         start_ff    <= '0;
      end else begin
         touched_ff  <= touched_in;
         pressing_ff <= pressing_in;
         start_ff    <= start_in;
      end
   end

   assign status.aged         = aged;
   assign status.touched      = touched_ff;
   assign status.touched_next = touched_in;

endmodule

`default_nettype wire

### rtl/epee_touch_lockout_core.sv
// epee_touch_lockout_core: epee scoring core, depress timing and lockout.
// Depends on etl_pkg, etl_csr and etl_side.
`timescale 1ns / 1ps
`default_nettype none

// Each req beat is one poll: a free-running microsecond timestamp and one
// on-target contact bit per fencer. Each poll yields exactly one rsp beat with
// locked_out, judged on the state before the poll, and both touch flags as
// they stand after it. The core takes one poll per clock while rsp_ready
// holds; the rsp beat passes from the poll register to the result register,
// which holds it while rsp_ready is low. Each poll updates the state of the two
// fencer timers, each a TIME_BITS subtract and two compares. Once a touch has
// aged past lockout_time_us, or both fencers have touched, every poll reports
// locked_out and the state freezes until reset. Time differences wrap modulo
// 2^TIME_BITS. Registers (csr_index): 0 lockout_time_us (reset 45000),
// 1 depress_time_us (reset 2000); write them only while the core is idle.
module epee_touch_lockout_core #(
   parameter int TIME_BITS = 32
) (
   input  wire logic                              clock,
   input  wire logic                              reset,
   // poll channel
   input  wire logic                              req_valid,
   output      logic                              req_ready,
   input  wire logic [31:0]                       req_now_us,
   input  wire logic                              req_contact_a,
   input  wire logic                              req_contact_b,
   // result channel
   output      logic                              rsp_valid,
   input  wire logic                              rsp_ready,
   output      logic                              rsp_locked_out,
   output      logic                              rsp_touch_a,
   output      logic                              rsp_touch_b,
   // register write channel
   input  wire logic                              csr_valid,
   output      logic                              csr_ready,
   input  wire logic [etl_pkg::CSR_IDX_BITS-1:0]  csr_index,
   input  wire logic [31:0]                       csr_wdata
);

   localparam int CMP_BITS = (TIME_BITS > 32) ? TIME_BITS : 32;

   // poll register
   logic                 poll_valid_ff, poll_valid_in;
   logic [31:0]          poll_now_ff;
   logic                 poll_ca_ff;
   logic                 poll_cb_ff;
   // result register
   logic                 rsp_valid_ff, rsp_valid_in;
   logic                 rsp_lock_ff;
   logic                 rsp_ta_ff;
   logic                 rsp_tb_ff;

   logic                 advance;
   logic                 lock;
   logic                 update;
   logic [CMP_BITS-1:0]  now_x;
   logic [TIME_BITS-1:0] now_t;
   logic [31:0]          lockout_time;
   logic [31:0]          depress_time;

   etl_pkg::side_status_type stat_a;
   etl_pkg::side_status_type stat_b;

   etl_csr u_csr (
      .clock        (clock),
      .reset        (reset),
      .csr_valid    (csr_valid),
      .csr_ready    (csr_ready),
      .csr_index    (csr_index),
      .csr_wdata    (csr_wdata),
      .lockout_time (lockout_time),
      .depress_time (depress_time)
   );

   // timestamp folded to TIME_BITS (zero-extend or truncate)
   assign now_x = CMP_BITS'(poll_now_ff);
   assign now_t = now_x[TIME_BITS-1:0];

   // poll moves to the result register when that register is free or drains
   assign advance   = poll_valid_ff && (!rsp_valid_ff || rsp_ready);
   assign req_ready = !poll_valid_ff || advance;

   // lockout is judged on the state before this poll
   assign lock   = stat_a.aged || stat_b.aged || (stat_a.touched && stat_b.touched);
   assign update = advance && !lock;

   etl_side #(.TIME_BITS(TIME_BITS)) u_side_a (
      .clock        (clock),
      .reset        (reset),
      .now          (now_t),
      .contact      (poll_ca_ff),
      .update       (update),
      .lockout_time (lockout_time),
      .depress_time (depress_time),
      .status       (stat_a)
   );

   etl_side #(.TIME_BITS(TIME_BITS)) u_side_b (
      .clock        (clock),
      .reset        (reset),
      .now          (now_t),
      .contact      (poll_cb_ff),
      .update       (update),
      .lockout_time (lockout_time),
      .depress_time (depress_time),
      .status       (stat_b)
   );

   always_comb begin
      poll_valid_in = poll_valid_ff;
      if (req_valid && req_ready) begin
         poll_valid_in = 1'b1;
      end else if (advance) begin
         poll_valid_in = 1'b0;
      end
   end

   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      if (advance) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_ready) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         poll_valid_ff <= 1'b0;
         rsp_valid_ff  <= 1'b0;
      end else begin
         poll_valid_ff <= poll_valid_in;
         rsp_valid_ff  <= rsp_valid_in;
      end
   end

   // payload registers, no reset
   always_ff @(posedge clock) begin
      if (req_valid && req_ready) begin
         poll_now_ff <= req_now_us;
         poll_ca_ff  <= req_contact_a;
         poll_cb_ff  <= req_contact_b;
      end
      if (advance) begin
         rsp_lock_ff <= lock;
         rsp_ta_ff   <= stat_a.touched_next;
         rsp_tb_ff   <= stat_b.touched_next;
      end
   end

   assign rsp_valid      = rsp_valid_ff;
   assign rsp_locked_out = rsp_lock_ff;
   assign rsp_touch_a    = rsp_ta_ff;
   assign rsp_touch_b    = rsp_tb_ff;

`ifndef NO_ASSERTIONS
   // lockout needs at least one registered touch
   a_lock_has_touch: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_locked_out) |-> (rsp_touch_a || rsp_touch_b))
      else $error("locked_out reported with no touch");

   // touches are sticky until reset
   a_touch_a_sticky: assert property (@(posedge clock) disable iff (reset)
      stat_a.touched |=> stat_a.touched)
      else $error("fencer A touch dropped");

   a_touch_b_sticky: assert property (@(posedge clock) disable iff (reset)
      stat_b.touched |=> stat_b.touched)
      else $error("fencer B touch dropped");

   // a locked poll leaves the touch state frozen
   a_lock_freezes: assert property (@(posedge clock) disable iff (reset)
      (advance && lock) |=> ($stable(stat_a.touched) && $stable(stat_b.touched)))
      else $error("touch state changed on a locked poll");
`endif

endmodule

`default_nettype wire
